/* src/tcc_pkg.sv */
// Shared types and codes for the TFTP client transfer controller.
package tcc_pkg;

    // Event modes
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_PACKET  = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;
    localparam logic [1:0] MODE_CHUNK   = 2'd3;

    // Received opcodes
    localparam logic [15:0] OPC_DATA  = 16'd3;
    localparam logic [15:0] OPC_ACK   = 16'd4;
    localparam logic [15:0] OPC_ERROR = 16'd5;

    // Send actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_REQUEST = 3'd1;
    localparam logic [2:0] ACT_ACK     = 3'd2;
    localparam logic [2:0] ACT_FETCH   = 3'd3;
    localparam logic [2:0] ACT_DATA    = 3'd4;
    localparam logic [2:0] ACT_RESEND  = 3'd5;

    // Transfer status
    localparam logic [1:0] STAT_IDLE   = 2'd0;
    localparam logic [1:0] STAT_BUSY   = 2'd1;
    localparam logic [1:0] STAT_DONE   = 2'd2;
    localparam logic [1:0] STAT_FAILED = 2'd3;

    // Failure causes
    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_RETRIES = 2'd1;
    localparam logic [1:0] CAUSE_SERVER  = 2'd2;
    localparam logic [1:0] CAUSE_READ    = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_DIRECTION   = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE  = 2'd1;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;
    localparam logic [1:0] REG_SERVER_PORT = 2'd3;

    // Configuration reset values
    localparam logic [15:0] BLOCK_SIZE_RESET  = 16'd512;
    localparam logic [15:0] SERVER_PORT_RESET = 16'd69;
    localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd1;

    typedef struct packed {
        logic        direction;
        logic [15:0] block_size;
        logic [7:0]  retry_limit;
        logic [15:0] server_port;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] opcode;
        logic [15:0] block;
        logic [15:0] payload_len;
        logic [15:0] src_port;
        logic [15:0] read_len;
        logic        read_fail;
    } t_event;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] out_block;
        logic [15:0] out_len;
        logic [15:0] dest_port;
        logic [1:0]  status;
        logic [1:0]  fail_cause;
        logic [15:0] error_code;
    } t_result;

endpackage

/* src/tcc_ctrl.sv */
// Transfer state registers and the per-item update and result logic.
module tcc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tcc_pkg::t_cfg    i_cfg,
    input  logic             i_fire,
    input  tcc_pkg::t_event  i_event,
    output tcc_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT_REQ,
        PH_WAIT,
        PH_FETCH,
        PH_DONE,
        PH_FAIL
    } t_phase;

    t_phase      r_phase,        n_phase;
    logic [15:0] r_block_number, n_block_number;
    logic        r_finished,     n_finished;
    logic [7:0]  r_retries_left, n_retries_left;
    logic [15:0] r_peer_port,    n_peer_port;
    logic        r_port_latched, n_port_latched;
    logic [15:0] r_last_len,     n_last_len;

    logic            waiting;
    logic [15:0]     prev_block;
    logic [15:0]     cur_dest;
    logic [15:0]     chunk_len;
    logic            tmo_fail;
    tcc_pkg::t_result res;

    // Shared terms of the update
    always_comb begin
        waiting    = (r_phase == PH_WAIT_REQ) || (r_phase == PH_WAIT);
        prev_block = r_block_number - 16'd1;
        cur_dest   = r_port_latched ? r_peer_port : i_cfg.server_port;
        chunk_len  = (i_event.read_len > i_cfg.block_size) ? i_cfg.block_size
                                                           : i_event.read_len;
        tmo_fail   = (r_retries_left <= 8'd1);
    end

    // Next state and result for one item
    always_comb begin
        n_phase        = r_phase;
        n_block_number = r_block_number;
        n_finished     = r_finished;
        n_retries_left = r_retries_left;
        n_peer_port    = r_peer_port;
        n_port_latched = r_port_latched;
        n_last_len     = r_last_len;
        res            = '0;

        case (i_event.mode)
            tcc_pkg::MODE_START: begin
                n_block_number = 16'd1;
                n_finished     = 1'b0;
                n_retries_left = i_cfg.retry_limit;
                n_peer_port    = 16'd0;
                n_port_latched = 1'b0;
                n_last_len     = 16'd0;
                n_phase        = PH_WAIT_REQ;
                res.action     = tcc_pkg::ACT_REQUEST;
                res.dest_port  = i_cfg.server_port;
            end
            tcc_pkg::MODE_CHUNK: begin
                if (r_phase == PH_FETCH) begin
                    if (i_event.read_fail) begin
                        n_phase        = PH_FAIL;
                        res.fail_cause = tcc_pkg::CAUSE_READ;
                    end else begin
                        if (chunk_len != i_cfg.block_size) begin
                            n_finished = 1'b1;
                        end
                        n_last_len     = chunk_len;
                        n_retries_left = i_cfg.retry_limit;
                        n_phase        = PH_WAIT;
                        n_block_number = r_block_number + 16'd1;
                        res.action     = tcc_pkg::ACT_DATA;
                        res.out_block  = r_block_number;
                        res.out_len    = chunk_len;
                        res.dest_port  = cur_dest;
                    end
                end
            end
            default: begin
                // Timeout tick, or a packet from a foreign port once latched
                if (waiting && ((i_event.mode == tcc_pkg::MODE_TIMEOUT) ||
                                (r_port_latched && (i_event.src_port != r_peer_port)))) begin
                    if (tmo_fail) begin
                        n_retries_left = 8'd0;
                        n_phase        = PH_FAIL;
                        res.fail_cause = tcc_pkg::CAUSE_RETRIES;
                    end else begin
                        n_retries_left = r_retries_left - 8'd1;
                        res.action     = tcc_pkg::ACT_RESEND;
                        res.dest_port  = cur_dest;
                        if (r_phase != PH_WAIT_REQ) begin
                            res.out_block = prev_block;
                            res.out_len   = r_last_len;
                        end
                    end
                end else if (waiting && (i_event.mode == tcc_pkg::MODE_PACKET)) begin
                    // Latch the peer on the first reply
                    n_port_latched = 1'b1;
                    n_peer_port    = i_event.src_port;
                    if (i_event.opcode == tcc_pkg::OPC_ERROR) begin
                        n_phase        = PH_FAIL;
                        res.fail_cause = tcc_pkg::CAUSE_SERVER;
                        res.error_code = i_event.block;
                    end else if (!i_cfg.direction && (i_event.opcode == tcc_pkg::OPC_DATA)) begin
                        if (i_event.block == r_block_number) begin
                            n_last_len     = 16'd0;
                            n_retries_left = i_cfg.retry_limit;
                            n_block_number = r_block_number + 16'd1;
                            if (r_finished || (i_event.payload_len != i_cfg.block_size)) begin
                                n_finished = 1'b1;
                                n_phase    = PH_DONE;
                            end else begin
                                n_phase = PH_WAIT;
                            end
                            res.action    = tcc_pkg::ACT_ACK;
                            res.out_block = i_event.block;
                            res.dest_port = i_event.src_port;
                        end else if (i_event.block == prev_block) begin
                            // Ack a duplicate again without advancing
                            n_last_len     = 16'd0;
                            n_retries_left = i_cfg.retry_limit;
                            n_phase        = PH_WAIT;
                            res.action     = tcc_pkg::ACT_ACK;
                            res.out_block  = i_event.block;
                            res.dest_port  = i_event.src_port;
                        end
                    end else if (i_cfg.direction && (i_event.opcode == tcc_pkg::OPC_ACK) &&
                                 (i_event.block == prev_block)) begin
                        if (r_finished) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase    = PH_FETCH;
                            res.action = tcc_pkg::ACT_FETCH;
                        end
                    end
                end
            end
        endcase

        // Report status of the phase left behind by this item
        case (n_phase)
            PH_IDLE: res.status = tcc_pkg::STAT_IDLE;
            PH_DONE: res.status = tcc_pkg::STAT_DONE;
            PH_FAIL: res.status = tcc_pkg::STAT_FAILED;
            default: res.status = tcc_pkg::STAT_BUSY;
        endcase
    end

    assign o_result = res;

    // Hold transfer state; advance on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_block_number <= 16'd1;
            r_finished     <= 1'b0;
            r_retries_left <= 8'd0;
            r_peer_port    <= 16'd0;
            r_port_latched <= 1'b0;
            r_last_len     <= 16'd0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_block_number <= n_block_number;
            r_finished     <= n_finished;
            r_retries_left <= n_retries_left;
            r_peer_port    <= n_peer_port;
            r_port_latched <= n_port_latched;
            r_last_len     <= n_last_len;
        end
    end

    // A failure cause only comes with the failed status
    a_cause_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.fail_cause != tcc_pkg::CAUSE_NONE) |-> (res.status == tcc_pkg::STAT_FAILED))
        else $error("fail cause without failed status");

    // A server error code only comes with the server error cause
    a_code_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.error_code != 16'd0) |-> (res.fail_cause == tcc_pkg::CAUSE_SERVER))
        else $error("error code without server error cause");

    // Sending data advances the block number by one
    a_data_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (res.action == tcc_pkg::ACT_DATA))
        |=> (r_block_number == $past(r_block_number) + 16'd1))
        else $error("block number did not advance after data");

    // State holds while no item is processed
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> ($stable(r_phase) && $stable(r_block_number) && $stable(r_retries_left)))
        else $error("transfer state changed without an item");

endmodule

/* src/tftp_client_transfer_control_top.sv */
// Top level: configuration registers, input stage, controller and result register.
// Path: an accepted item is captured in the input register, and its result in the
// result register when the controller fires it and the output is not blocked.
// Throughput: one item per cycle while the output is not stalled; the input register
// takes an item while a stalled result waits in the result register.
// Reset: synchronous active low; clears both stages, restores register defaults
// and returns the transfer to idle with block number one.
module tftp_client_transfer_control_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_opcode,
    input  logic [15:0] i_block,
    input  logic [15:0] i_payload_len,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_read_len,
    input  logic        i_read_fail,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_action,
    output logic [15:0] o_out_block,
    output logic [15:0] o_out_len,
    output logic [15:0] o_dest_port,
    output logic [1:0]  o_status,
    output logic [1:0]  o_fail_cause,
    output logic [15:0] o_error_code
);

    tcc_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    tcc_pkg::t_event  r_event;
    logic             r_out_valid;
    tcc_pkg::t_result r_result;
    tcc_pkg::t_result step_result;
    logic             out_blocked;
    logic             fire;
    logic             accept;

    assign out_blocked = r_out_valid && i_out_stall;
    assign fire        = r_in_valid && !out_blocked;
    assign o_in_stall  = r_in_valid && out_blocked;
    assign accept      = i_in_valid && !o_in_stall;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction   <= 1'b0;
            r_cfg.block_size  <= tcc_pkg::BLOCK_SIZE_RESET;
            r_cfg.retry_limit <= tcc_pkg::RETRY_LIMIT_RESET;
            r_cfg.server_port <= tcc_pkg::SERVER_PORT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcc_pkg::REG_DIRECTION:   r_cfg.direction   <= i_cfg_data[0];
                tcc_pkg::REG_BLOCK_SIZE:  r_cfg.block_size  <= i_cfg_data;
                tcc_pkg::REG_RETRY_LIMIT: r_cfg.retry_limit <= i_cfg_data[7:0];
                tcc_pkg::REG_SERVER_PORT: r_cfg.server_port <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture incoming item; drop it once handed to the controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event.mode        <= i_mode;
            r_event.opcode      <= i_opcode;
            r_event.block       <= i_block;
            r_event.payload_len <= i_payload_len;
            r_event.src_port    <= i_src_port;
            r_event.read_len    <= i_read_len;
            r_event.read_fail   <= i_read_fail;
        end
    end

    tcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_fire   (fire),
        .i_event  (r_event),
        .o_result (step_result)
    );

    // Hold result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_action     = r_result.action;
    assign o_out_block  = r_result.out_block;
    assign o_out_len    = r_result.out_len;
    assign o_dest_port  = r_result.dest_port;
    assign o_status     = r_result.status;
    assign o_fail_cause = r_result.fail_cause;
    assign o_error_code = r_result.error_code;

endmodule

/* dv/tftp_client_transfer_control_top_tb.sv */
// Self-checking testbench for the TFTP client transfer controller top level.
module tftp_client_transfer_control_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_MAX      = 65464;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_WAIT  = 6;
    localparam int NUM_SETTINGS = 10;
    localparam int SETTING_ITEMS = 112;
    localparam int MAX_REPORTS  = 40;

    // Transfer phases kept by the predictor
    typedef enum logic [2:0] {
        XF_IDLE,
        XF_WAIT_REQ,
        XF_WAIT,
        XF_FETCH,
        XF_DONE,
        XF_FAIL
    } t_xfer_phase;

    // Predicts the reply to every accepted event and checks the replies that come out
    class t_reply_board;
        logic        dir;
        logic [15:0] bsize;
        logic [7:0]  rlimit;
        logic [15:0] srv_port;
        t_xfer_phase phase;
        logic [15:0] blk_num;
        logic        finished;
        logic [7:0]  retries;
        logic [15:0] peer;
        logic        latched;
        logic [15:0] last_len;
        tcc_pkg::t_result replies_due[$];
        int          errors;
        int          n_items;
        int          n_action[8];
        int          n_done;
        int          n_cause[4];

        function new();
            dir      = 1'b0;
            bsize    = tcc_pkg::BLOCK_SIZE_RESET;
            rlimit   = tcc_pkg::RETRY_LIMIT_RESET;
            srv_port = tcc_pkg::SERVER_PORT_RESET;
            phase    = XF_IDLE;
            blk_num  = 16'd1;
            finished = 1'b0;
            retries  = 8'd0;
            peer     = 16'd0;
            latched  = 1'b0;
            last_len = 16'd0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                tcc_pkg::REG_DIRECTION:   dir = val[0];
                tcc_pkg::REG_BLOCK_SIZE:  bsize = val;
                tcc_pkg::REG_RETRY_LIMIT: rlimit = val[7:0];
                default:                  srv_port = val;
            endcase
        endfunction

        function logic [1:0] status_now();
            case (phase)
                XF_IDLE: return tcc_pkg::STAT_IDLE;
                XF_DONE: return tcc_pkg::STAT_DONE;
                XF_FAIL: return tcc_pkg::STAT_FAILED;
                default: return tcc_pkg::STAT_BUSY;
            endcase
        endfunction

        function logic [15:0] dest_now();
            return latched ? peer : srv_port;
        endfunction

        function tcc_pkg::t_result reply(logic [2:0] act, logic [15:0] blk,
                                         logic [15:0] len, logic [15:0] dest,
                                         logic [1:0] cause, logic [15:0] code);
            tcc_pkg::t_result r;
            r.action     = act;
            r.out_block  = blk;
            r.out_len    = len;
            r.dest_port  = dest;
            r.status     = status_now();
            r.fail_cause = cause;
            r.error_code = code;
            return r;
        endfunction

        // Resend the last packet, or fail once the retries run out
        function tcc_pkg::t_result time_out();
            if (retries <= 8'd1) begin
                retries = 8'd0;
                phase   = XF_FAIL;
                return reply(tcc_pkg::ACT_NONE, 16'd0, 16'd0, 16'd0,
                             tcc_pkg::CAUSE_RETRIES, 16'd0);
            end
            retries = retries - 8'd1;
            if (phase == XF_WAIT_REQ)
                return reply(tcc_pkg::ACT_RESEND, 16'd0, 16'd0, dest_now(),
                             tcc_pkg::CAUSE_NONE, 16'd0);
            return reply(tcc_pkg::ACT_RESEND, blk_num - 16'd1, last_len, dest_now(),
                         tcc_pkg::CAUSE_NONE, 16'd0);
        endfunction

        // Advance the transfer by one event and queue the reply it must produce
        function void note_item(tcc_pkg::t_event ev);
            tcc_pkg::t_result r;
            logic        waiting;
            logic [15:0] prev;
            logic [15:0] rlen;
            t_xfer_phase was;
            was     = phase;
            waiting = (phase == XF_WAIT_REQ) || (phase == XF_WAIT);
            prev    = blk_num - 16'd1;
            r       = reply(tcc_pkg::ACT_NONE, 16'd0, 16'd0, 16'd0,
                            tcc_pkg::CAUSE_NONE, 16'd0);
            case (ev.mode)
                tcc_pkg::MODE_START: begin
                    blk_num  = 16'd1;
                    finished = 1'b0;
                    retries  = rlimit;
                    peer     = 16'd0;
                    latched  = 1'b0;
                    last_len = 16'd0;
                    phase    = XF_WAIT_REQ;
                    r = reply(tcc_pkg::ACT_REQUEST, 16'd0, 16'd0, srv_port,
                              tcc_pkg::CAUSE_NONE, 16'd0);
                end
                tcc_pkg::MODE_TIMEOUT: begin
                    if (waiting)
                        r = time_out();
                end
                tcc_pkg::MODE_CHUNK: begin
                    if (phase == XF_FETCH) begin
                        if (ev.read_fail) begin
                            phase = XF_FAIL;
                            r = reply(tcc_pkg::ACT_NONE, 16'd0, 16'd0, 16'd0,
                                      tcc_pkg::CAUSE_READ, 16'd0);
                        end else begin
                            // saturate an over-long chunk to one block
                            rlen = (ev.read_len > bsize) ? bsize : ev.read_len;
                            if (rlen != bsize)
                                finished = 1'b1;
                            last_len = rlen;
                            retries  = rlimit;
                            phase    = XF_WAIT;
                            r = reply(tcc_pkg::ACT_DATA, blk_num, rlen, dest_now(),
                                      tcc_pkg::CAUSE_NONE, 16'd0);
                            blk_num = blk_num + 16'd1;
                        end
                    end
                end
                default: begin
                    if (waiting) begin
                        // first reply latches the peer; other ports count as a timeout
                        if (!latched) begin
                            peer    = ev.src_port;
                            latched = 1'b1;
                        end
                        if (ev.src_port != peer) begin
                            r = time_out();
                        end else if (ev.opcode == tcc_pkg::OPC_ERROR) begin
                            phase = XF_FAIL;
                            r = reply(tcc_pkg::ACT_NONE, 16'd0, 16'd0, 16'd0,
                                      tcc_pkg::CAUSE_SERVER, ev.block);
                        end else if (!dir && ev.opcode == tcc_pkg::OPC_DATA &&
                                     ev.block == blk_num) begin
                            if (ev.payload_len != bsize)
                                finished = 1'b1;
                            last_len = 16'd0;
                            retries  = rlimit;
                            phase    = finished ? XF_DONE : XF_WAIT;
                            r = reply(tcc_pkg::ACT_ACK, ev.block, 16'd0, dest_now(),
                                      tcc_pkg::CAUSE_NONE, 16'd0);
                            blk_num = blk_num + 16'd1;
                        end else if (!dir && ev.opcode == tcc_pkg::OPC_DATA &&
                                     ev.block == prev) begin
                            // duplicate block: ack again, do not advance
                            last_len = 16'd0;
                            retries  = rlimit;
                            phase    = XF_WAIT;
                            r = reply(tcc_pkg::ACT_ACK, ev.block, 16'd0, dest_now(),
                                      tcc_pkg::CAUSE_NONE, 16'd0);
                        end else if (dir && ev.opcode == tcc_pkg::OPC_ACK &&
                                     ev.block == prev) begin
                            if (finished) begin
                                phase = XF_DONE;
                                r = reply(tcc_pkg::ACT_NONE, 16'd0, 16'd0, 16'd0,
                                          tcc_pkg::CAUSE_NONE, 16'd0);
                            end else begin
                                phase = XF_FETCH;
                                r = reply(tcc_pkg::ACT_FETCH, 16'd0, 16'd0, 16'd0,
                                          tcc_pkg::CAUSE_NONE, 16'd0);
                            end
                        end
                    end
                end
            endcase
            n_items++;
            n_action[r.action]++;
            if (r.fail_cause != tcc_pkg::CAUSE_NONE)
                n_cause[r.fail_cause]++;
            if (phase == XF_DONE && was != XF_DONE)
                n_done++;
            replies_due.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch: expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        // Compare one reply with the oldest prediction
        function void check_result(tcc_pkg::t_result got);
            tcc_pkg::t_result want;
            if (replies_due.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: reply with none expected: expected nothing, actual action %0d",
                             $time, got.action);
                return;
            end
            want = replies_due.pop_front();
            compare_field("action", 16'(want.action), 16'(got.action));
            compare_field("out_block", want.out_block, got.out_block);
            compare_field("out_len", want.out_len, got.out_len);
            compare_field("dest_port", want.dest_port, got.dest_port);
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("fail_cause", 16'(want.fail_cause), 16'(got.fail_cause));
            compare_field("error_code", want.error_code, got.error_code);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_mode;
    logic [15:0] i_opcode;
    logic [15:0] i_block;
    logic [15:0] i_payload_len;
    logic [15:0] i_src_port;
    logic [15:0] i_read_len;
    logic        i_read_fail;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_action;
    logic [15:0] o_out_block;
    logic [15:0] o_out_len;
    logic [15:0] o_dest_port;
    logic [1:0]  o_status;
    logic [1:0]  o_fail_cause;
    logic [15:0] o_error_code;

    t_reply_board    board;
    logic [15:0]     peer_pick = 16'd0;
    int              holds_wanted = 0;
    int              holds_given = 0;

    tftp_client_transfer_control_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_opcode      (i_opcode),
        .i_block       (i_block),
        .i_payload_len (i_payload_len),
        .i_src_port    (i_src_port),
        .i_read_len    (i_read_len),
        .i_read_fail   (i_read_fail),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_action      (o_action),
        .o_out_block   (o_out_block),
        .o_out_len     (o_out_len),
        .o_dest_port   (o_dest_port),
        .o_status      (o_status),
        .o_fail_cause  (o_fail_cause),
        .o_error_code  (o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic tcc_pkg::t_event make_ev(logic [1:0] m, logic [15:0] opc,
                                                logic [15:0] blk, logic [15:0] plen,
                                                logic [15:0] sport, logic [15:0] rlen,
                                                logic rfail);
        tcc_pkg::t_event ev;
        ev.mode        = m;
        ev.opcode      = opc;
        ev.block       = blk;
        ev.payload_len = plen;
        ev.src_port    = sport;
        ev.read_len    = rlen;
        ev.read_fail   = rfail;
        return ev;
    endfunction

    // Pick the next event: mostly what the transfer is waiting for, some noise
    function automatic tcc_pkg::t_event next_event();
        tcc_pkg::t_event ev;
        int          roll;
        int          longer;
        logic [15:0] bs;
        logic [15:0] port;
        ev.mode        = tcc_pkg::MODE_PACKET;
        ev.opcode      = 16'($urandom);
        ev.block       = 16'($urandom);
        ev.payload_len = 16'($urandom_range(0, LEN_MAX));
        ev.src_port    = 16'($urandom);
        ev.read_len    = 16'($urandom_range(0, LEN_MAX));
        ev.read_fail   = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        bs   = board.bsize;
        port = board.latched ? board.peer : peer_pick;
        if (roll < 7) begin
            ev.mode = 2'($urandom_range(0, 3));
            return ev;
        end
        if (roll < 9 || board.phase inside {XF_IDLE, XF_DONE, XF_FAIL}) begin
            ev.mode   = tcc_pkg::MODE_START;
            peer_pick = 16'($urandom);
            return ev;
        end
        roll = $urandom_range(0, 99);
        if (board.phase == XF_FETCH) begin
            ev.mode      = tcc_pkg::MODE_CHUNK;
            ev.read_fail = (roll < 4);
            if (roll < 70) begin
                ev.read_len = bs;
            end else if (roll < 82) begin
                longer      = int'(bs) + $urandom_range(1, 64);
                ev.read_len = 16'((longer > LEN_MAX) ? LEN_MAX : longer);
            end else if (roll < 92) begin
                ev.read_len = 16'($urandom_range(0, int'(bs)));
            end
            return ev;
        end
        // waiting for a reply from the server
        ev.src_port = port;
        if (roll < 8) begin
            ev.mode = tcc_pkg::MODE_TIMEOUT;
        end else if (roll < 13) begin
            ev.src_port = port ^ 16'($urandom_range(1, 65535));
        end else if (roll < 16) begin
            ev.opcode = tcc_pkg::OPC_ERROR;
        end else if (roll < 18) begin
            ev.opcode = board.dir ? tcc_pkg::OPC_DATA : tcc_pkg::OPC_ACK;
        end else if (roll < 20) begin
            // keep the random opcode
        end else if (board.dir) begin
            ev.opcode = tcc_pkg::OPC_ACK;
            ev.block  = (roll < 24) ? board.blk_num : board.blk_num - 16'd1;
        end else begin
            ev.opcode = tcc_pkg::OPC_DATA;
            ev.block  = (roll < 25) ? board.blk_num - 16'd1 : board.blk_num;
            if ($urandom_range(0, 6) != 0)
                ev.payload_len = bs;
        end
        return ev;
    endfunction

    // Offer one item and hold it until accepted
    task automatic send_item(input tcc_pkg::t_event ev);
        i_in_valid    <= 1'b1;
        i_mode        <= ev.mode;
        i_opcode      <= ev.opcode;
        i_block       <= ev.block;
        i_payload_len <= ev.payload_len;
        i_src_port    <= ev.src_port;
        i_read_len    <= ev.read_len;
        i_read_fail   <= ev.read_fail;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        board.note_item(ev);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every predicted reply has come out
    task automatic wait_all_replies();
        i_in_valid <= 1'b0;
        while (board.replies_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // Write all four registers on back-to-back cycles
    task automatic program_regs(input logic d, input logic [15:0] bs, input logic [7:0] rl,
                                input logic [15:0] sp);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tcc_pkg::REG_DIRECTION;
        i_cfg_data  <= {15'd0, d};
        board.set_reg(tcc_pkg::REG_DIRECTION, {15'd0, d});
        @(posedge i_clk);
        i_cfg_index <= tcc_pkg::REG_BLOCK_SIZE;
        i_cfg_data  <= bs;
        board.set_reg(tcc_pkg::REG_BLOCK_SIZE, bs);
        @(posedge i_clk);
        i_cfg_index <= tcc_pkg::REG_RETRY_LIMIT;
        i_cfg_data  <= {8'd0, rl};
        board.set_reg(tcc_pkg::REG_RETRY_LIMIT, {8'd0, rl});
        @(posedge i_clk);
        i_cfg_index <= tcc_pkg::REG_SERVER_PORT;
        i_cfg_data  <= sp;
        board.set_reg(tcc_pkg::REG_SERVER_PORT, sp);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random items in bursts with gaps between them
    task automatic run_random(input int count);
        int left;
        left = 0;
        repeat (count) begin
            if (left == 0) begin
                pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                left = $urandom_range(1, 30);
            end
            send_item(next_event());
            left--;
        end
    endtask

    // Receiver stall pattern: quiet stretches, random stalls, periodic stalls, long holds
    initial begin : out_stall_pattern
        int len;
        int kind;
        int pct;
        int k;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            kind = $urandom_range(0, 14);
            len  = $urandom_range(8, 60);
            if (holds_wanted > holds_given) begin
                holds_given++;
                i_out_stall <= 1'b1;
                repeat ($urandom_range(60, 120)) @(posedge i_clk);
            end else if (kind == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(30, 80)) @(posedge i_clk);
            end else if (kind < 5) begin
                i_out_stall <= 1'b0;
                repeat (len) @(posedge i_clk);
            end else if (kind < 10) begin
                pct = $urandom_range(10, 70);
                repeat (len) begin
                    i_out_stall <= ($urandom_range(0, 99) < pct);
                    @(posedge i_clk);
                end
            end else begin
                k = $urandom_range(2, 5);
                for (int c = 0; c < len; c++) begin
                    i_out_stall <= (c % k == 0);
                    @(posedge i_clk);
                end
            end
        end
    end

    // Check every reply taken from the output channel
    initial begin : reply_monitor
        tcc_pkg::t_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.action     = o_action;
                got.out_block  = o_out_block;
                got.out_len    = o_out_len;
                got.dest_port  = o_dest_port;
                got.status     = o_status;
                got.fail_cause = o_fail_cause;
                got.error_code = o_error_code;
                board.check_result(got);
            end
        end
    end

    // End the run when neither channel moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        logic        d;
        logic [15:0] bs;
        logic [7:0]  rl;
        logic [15:0] sp;
        board         = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= tcc_pkg::REG_DIRECTION;
        i_cfg_data    <= 16'd0;
        i_in_valid    <= 1'b0;
        i_mode        <= tcc_pkg::MODE_START;
        i_opcode      <= 16'd0;
        i_block       <= 16'd0;
        i_payload_len <= 16'd0;
        i_src_port    <= 16'd0;
        i_read_len    <= 16'd0;
        i_read_fail   <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Get with smallest block size: resend, latch, duplicate, foreign port,
        // ignored packets, short block, server error, retries exhausted
        program_regs(1'b0, 16'd8, 8'd3, 16'hFFFF);
        send_item(make_ev(tcc_pkg::MODE_START, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_TIMEOUT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_PACKET, tcc_pkg::OPC_DATA, 16'd1, 16'd8, 16'h8001,
                          16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_PACKET, tcc_pkg::OPC_DATA, 16'd1, 16'd8, 16'h8001,
                          16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_PACKET, tcc_pkg::OPC_DATA, 16'd3, 16'd8, 16'h8001,
                          16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_PACKET, tcc_pkg::OPC_DATA, 16'd2, 16'd8, 16'h0000,
                          16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_PACKET, 16'hFFFF, 16'd2, 16'd8, 16'h8001,
                          16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_PACKET, tcc_pkg::OPC_ACK, 16'd1, 16'd0, 16'h8001,
                          16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_CHUNK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd8, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_PACKET, tcc_pkg::OPC_DATA, 16'd2, 16'd0, 16'h8001,
                          16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_TIMEOUT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_START, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_PACKET, tcc_pkg::OPC_ERROR, 16'hFFFF, 16'd0,
                          16'hFFFF, 16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_START, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        repeat (3)
            send_item(make_ev(tcc_pkg::MODE_TIMEOUT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                              1'b0));
        wait_all_replies();

        // Put with largest block size and retry limit zero: full block, short
        // last block, final ack, read failure, immediate timeout failure
        program_regs(1'b1, 16'(LEN_MAX), 8'd0, 16'd0);
        send_item(make_ev(tcc_pkg::MODE_START, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_PACKET, tcc_pkg::OPC_ACK, 16'd0, 16'd0, 16'hFFFF,
                          16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_CHUNK, 16'd0, 16'd0, 16'd0, 16'd0, 16'(LEN_MAX),
                          1'b0));
        send_item(make_ev(tcc_pkg::MODE_PACKET, tcc_pkg::OPC_DATA, 16'd0, 16'd0, 16'hFFFF,
                          16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_PACKET, tcc_pkg::OPC_ACK, 16'd1, 16'd0, 16'hFFFF,
                          16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_CHUNK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_PACKET, tcc_pkg::OPC_ACK, 16'd2, 16'd0, 16'hFFFF,
                          16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_START, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_PACKET, tcc_pkg::OPC_ACK, 16'd0, 16'd0, 16'h1234,
                          16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_CHUNK, 16'd0, 16'd0, 16'd0, 16'd0, 16'd8, 1'b1));
        send_item(make_ev(tcc_pkg::MODE_START, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        send_item(make_ev(tcc_pkg::MODE_TIMEOUT, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
        wait_all_replies();

        // Random transfers across a range of settings, each phase drained before rewrite
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            d = p[0];
            case (p % 5)
                0:       bs = 16'd8;
                1:       bs = 16'(LEN_MAX);
                2:       bs = 16'($urandom_range(9, 64));
                3:       bs = tcc_pkg::BLOCK_SIZE_RESET;
                default: bs = 16'($urandom_range(8, LEN_MAX));
            endcase
            case (p % 4)
                0:       rl = 8'd1;
                1:       rl = 8'd255;
                2:       rl = 8'($urandom_range(2, 6));
                default: rl = 8'd0;
            endcase
            if (p == 0)
                sp = 16'd0;
            else if (p == 1)
                sp = 16'hFFFF;
            else
                sp = 16'($urandom);
            program_regs(d, bs, rl, sp);
            if (p == 3 || p == 7)
                holds_wanted++;
            run_random(SETTING_ITEMS);
            wait_all_replies();
        end

        $display("Covered %0d items: %0d requests, %0d acks, %0d fetches, %0d data blocks, %0d resends",
                 board.n_items, board.n_action[tcc_pkg::ACT_REQUEST],
                 board.n_action[tcc_pkg::ACT_ACK], board.n_action[tcc_pkg::ACT_FETCH],
                 board.n_action[tcc_pkg::ACT_DATA], board.n_action[tcc_pkg::ACT_RESEND]);
        $display("%0d transfers completed; failures: %0d retries, %0d server error, %0d read",
                 board.n_done, board.n_cause[tcc_pkg::CAUSE_RETRIES],
                 board.n_cause[tcc_pkg::CAUSE_SERVER], board.n_cause[tcc_pkg::CAUSE_READ]);
        if (board.errors == 0 && board.replies_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
src/tcc_pkg.sv
src/tcc_ctrl.sv
src/tftp_client_transfer_control_top.sv
dv/tftp_client_transfer_control_top_tb.sv
